>>> rtl/bec_pkg.sv
// ---------------------------------------------------------------------------
// Block exponential covariance package
// Shared payload types, register codes, widths and the exponential table.
// ---------------------------------------------------------------------------
package bec_pkg;

   localparam int MAX_TRENDS    = 3;
   localparam int MAX_LOCATIONS = 1024;
   localparam int FRAC_BITS     = 16;

   // Positions and location counts are handled at this width so that the
   // full range of MAX_LOCATIONS compares correctly.
   localparam int LOCS_W = 13;
   localparam int POS_W  = 12;

   // The ratio distance/range is formed in Q4.16 and only values below 16
   // matter, so the quotient has 20 bits.
   localparam int XF         = 16;
   localparam int Q_W        = XF + 4;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = Q_W / DIV_STEPS;
   localparam int NUM_W      = 32 + XF;

   localparam int E_W    = FRAC_BITS + 1;
   localparam int PROD_W = 32 + E_W;

   localparam int EXP_BITS   = 8;
   localparam int EXP_STAGES = EXP_BITS + 1;

   localparam logic [30:0] Q30_ONE  = 31'(1) << 30;
   localparam logic [61:0] Q30_HALF = 62'(1) << 29;

   // exp(-w) in Q30 for the ratio bits of weight 8 down to 1/16.
   localparam logic [29:0] EXP_BIT_TABLE [EXP_BITS] = '{
      30'd360200,    30'd19666268,  30'd145315154, 30'd395007542,
      30'd651257337, 30'd836230973, 30'd947573834, 30'd1008687096
   };

   typedef enum logic [2:0] {
      REG_TREND_COUNT    = 3'd0,
      REG_LOCATION_COUNT = 3'd1,
      REG_SILL_FIRST     = 3'd2,
      REG_SILL_SECOND    = 3'd3,
      REG_SILL_THIRD     = 3'd4,
      REG_RANGE_FIRST    = 3'd5,
      REG_RANGE_SECOND   = 3'd6,
      REG_RANGE_THIRD    = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [1:0]  trend_index;
      logic [9:0]  first_location;
      logic [9:0]  second_location;
      logic [31:0] distance;
   } req_type;

   typedef struct packed {
      logic [11:0] row_position;
      logic [11:0] column_position;
      logic [31:0] covariance;
      logic        last_of_run;
      logic        error_flag;
   } rsp_type;

   // Decoded request that travels alongside the arithmetic.
   typedef struct packed {
      logic [POS_W-1:0] pos_i;
      logic [POS_W-1:0] pos_j;
      logic [31:0]      sill;
      logic             err;
      logic             diag;
      logic             zero;
   } side_type;

   typedef struct packed {
      side_type        side;
      logic [31:0]     range;
      logic [31:0]     rem;
      logic [Q_W-1:0]  stream;
      logic [Q_W-1:0]  quo;
   } div_type;

   typedef struct packed {
      side_type       side;
      logic [Q_W-1:0] x;
   } quo_type;

   typedef struct packed {
      side_type       side;
      logic [Q_W-1:0] x;
      logic [30:0]    acc;
      logic [25:0]    r30;
      logic [21:0]    sq;
      logic [17:0]    cube;
      logic [30:0]    poly;
   } exp_type;

   typedef struct packed {
      side_type    side;
      logic [31:0] cov;
   } cov_type;

   // Product of two Q30 values, rounded half up.
   function automatic logic [30:0] q30_mul(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] p;
      p = 62'(a) * 62'(b) + Q30_HALF;
      return p[60:30];
   endfunction

   // Truncating division by six through a reciprocal, exact for 18-bit inputs.
   function automatic logic [15:0] div6(input logic [17:0] c);
      logic [36:0] p;
      p = 37'(c) * 37'(349526);
      return p[36:21];
   endfunction

endpackage

>>> rtl/bec_divider.sv
// ---------------------------------------------------------------------------
// Ratio divider
// Restoring division of distance<<16 by range, four quotient bits a stage.
// ---------------------------------------------------------------------------
module bec_divider (
   input  logic             clock,
   input  logic             reset,
   input  bec_pkg::div_type in_data,
   input  logic             in_valid,
   output logic             in_stall,
   output bec_pkg::quo_type out_data,
   output logic             out_valid,
   input  logic             out_stall
);

   localparam int N = bec_pkg::DIV_STAGES;

   bec_pkg::div_type st_ff [N];
   bec_pkg::div_type st_in [N];
   logic [N-1:0]     v_ff;
   logic [N:0]       v_chain;
   logic [N:0]       rdy;

   function automatic bec_pkg::div_type div_step(input bec_pkg::div_type d);
      bec_pkg::div_type r;
      logic [32:0]      tmp;
      logic             ge;
      r = d;
      for (int n = 0; n < bec_pkg::DIV_STEPS; n++) begin
         tmp      = {r.rem, r.stream[bec_pkg::Q_W-1]};
         ge       = (tmp >= {1'b0, r.range});
         r.rem    = ge ? 32'(tmp - {1'b0, r.range}) : tmp[31:0];
         r.quo    = {r.quo[bec_pkg::Q_W-2:0], ge};
         r.stream = {r.stream[bec_pkg::Q_W-2:0], 1'b0};
      end
      return r;
   endfunction

   assign rdy[N]   = !out_stall;
   assign in_stall = !rdy[0];
   assign v_chain  = {v_ff, in_valid};

   for (genvar k = 0; k < N; k++) begin : g_stage
      assign rdy[k] = !v_ff[k] || rdy[k+1];

      if (k == 0) begin : g_first
         assign st_in[k] = div_step(in_data);
      end else begin : g_rest
         assign st_in[k] = div_step(st_ff[k-1]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_chain[k];
         end
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid     = v_ff[N-1];
   assign out_data.side = st_ff[N-1].side;
   assign out_data.x    = st_ff[N-1].quo;

endmodule

>>> rtl/bec_exp.sv
// ---------------------------------------------------------------------------
// Exponential and scaling pipeline
// Forms exp(-x) as a product of per-bit constants and a cubic correction,
// then scales the sill by it.
// ---------------------------------------------------------------------------
module bec_exp (
   input  logic             clock,
   input  logic             reset,
   input  bec_pkg::quo_type in_data,
   input  logic             in_valid,
   output logic             in_stall,
   output bec_pkg::cov_type out_data,
   output logic             out_valid,
   input  logic             out_stall
);

   localparam int N     = bec_pkg::EXP_STAGES;
   localparam int F     = bec_pkg::FRAC_BITS;
   localparam int E_W_L = bec_pkg::E_W;

   bec_pkg::exp_type st_ff [N];
   bec_pkg::exp_type st_in [N];
   bec_pkg::exp_type head;
   logic [N-1:0]     v_ff;
   logic [N:0]       v_chain;
   logic [N+1:0]     rdy;
   bec_pkg::cov_type fin_ff;
   bec_pkg::cov_type fin_in;
   logic             fin_v_ff;

   always_comb begin
      head      = '0;
      head.side = in_data.side;
      head.x    = in_data.x;
      head.acc  = bec_pkg::Q30_ONE;
      head.r30  = {in_data.x[11:0], 14'b0};
   end

   assign rdy[N+1] = !out_stall;
   assign rdy[N]   = !fin_v_ff || rdy[N+1];
   assign in_stall = !rdy[0];
   assign v_chain  = {v_ff, in_valid};

   for (genvar k = 0; k < N; k++) begin : g_stage
      bec_pkg::exp_type prev;

      assign rdy[k] = !v_ff[k] || rdy[k+1];

      if (k == 0) begin : g_first
         assign prev = head;
      end else begin : g_rest
         assign prev = st_ff[k-1];
      end

      if (k < bec_pkg::EXP_BITS) begin : g_bit
         always_comb begin
            logic [51:0] sq_p;
            logic [47:0] cube_p;
            logic [31:0] poly_s;
            st_in[k] = prev;
            sq_p     = 52'(prev.r30) * 52'(prev.r30);
            cube_p   = 48'(prev.sq) * 48'(prev.r30);
            poly_s   = 32'(bec_pkg::Q30_ONE) - 32'(prev.r30) + 32'(prev.sq >> 1)
                       - 32'(bec_pkg::div6(prev.cube));
            if (prev.x[bec_pkg::Q_W-1-k]) begin
               st_in[k].acc = bec_pkg::q30_mul(prev.acc, {1'b0, bec_pkg::EXP_BIT_TABLE[k]});
            end
            // The cubic correction is built alongside the first few products.
            if (k == 0) begin
               st_in[k].sq = sq_p[51:30];
            end
            if (k == 1) begin
               st_in[k].cube = cube_p[47:30];
            end
            if (k == 2) begin
               st_in[k].poly = poly_s[30:0];
            end
         end
      end else begin : g_poly
         always_comb begin
            st_in[k]     = prev;
            st_in[k].acc = bec_pkg::q30_mul(prev.acc, prev.poly);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_chain[k];
         end
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      logic [30:0]             e_sum;
      logic [E_W_L-1:0]        e_val;
      logic [bec_pkg::PROD_W-1:0] prod;
      e_sum       = st_ff[N-1].acc + (31'(1) << (29 - F));
      e_val       = e_sum[30:30-F];
      prod        = bec_pkg::PROD_W'(st_ff[N-1].side.sill) * bec_pkg::PROD_W'(e_val)
                    + (bec_pkg::PROD_W'(1) << (F - 1));
      fin_in.side = st_ff[N-1].side;
      fin_in.cov  = prod[F+31:F];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (rdy[N]) begin
         fin_v_ff <= v_ff[N-1];
      end
      if (rdy[N]) begin
         fin_ff <= fin_in;
      end
   end

   assign out_valid = fin_v_ff;
   assign out_data  = fin_ff;

endmodule

>>> rtl/block_exponential_covariance.sv
// ---------------------------------------------------------------------------
// Block exponential covariance kernel
// Emits block-diagonal exponential covariance entries for location pairs.
// ---------------------------------------------------------------------------
// A request enters a 17-stage pipeline (decode, five divider stages of four
// quotient bits each, nine multiply stages for the exponential, one scaling
// stage and the result register), and its result is then presented on the
// result port. A new request may enter every cycle while the pipeline does
// not stall; the result port then sets the pace, since an off-diagonal pair
// delivers two transactions from the result register, while diagonal and
// error requests deliver one each. Configuration is written through the APB
// port; the user must write it only while no request is in flight, as the
// block itself does not enforce this.
module block_exponential_covariance (
   input  logic             clock,
   input  logic             reset,
   input  bec_pkg::req_type req_data,
   input  logic             req_valid,
   output logic             req_stall,
   output bec_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int LW = bec_pkg::LOCS_W;
   localparam logic [LW-1:0] MaxLocs = LW'(bec_pkg::MAX_LOCATIONS);

   logic [1:0]  trend_count_ff;
   logic [10:0] location_count_ff;
   logic [31:0] sill_ff [3];
   logic [31:0] range_ff [3];

   // Configuration port.
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trend_count_ff    <= 2'd1;
         location_count_ff <= 11'd1;
         for (int t = 0; t < 3; t++) begin
            sill_ff[t]  <= 32'd65536;
            range_ff[t] <= 32'd65536;
         end
      end else if (psel && penable && pwrite && pready) begin
         unique case (bec_pkg::reg_idx_type'(paddr[4:2]))
            bec_pkg::REG_TREND_COUNT:    trend_count_ff    <= pwdata[1:0];
            bec_pkg::REG_LOCATION_COUNT: location_count_ff <= pwdata[10:0];
            bec_pkg::REG_SILL_FIRST:     sill_ff[0]        <= pwdata;
            bec_pkg::REG_SILL_SECOND:    sill_ff[1]        <= pwdata;
            bec_pkg::REG_SILL_THIRD:     sill_ff[2]        <= pwdata;
            bec_pkg::REG_RANGE_FIRST:    range_ff[0]       <= pwdata;
            bec_pkg::REG_RANGE_SECOND:   range_ff[1]       <= pwdata;
            bec_pkg::REG_RANGE_THIRD:    range_ff[2]       <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (bec_pkg::reg_idx_type'(paddr[4:2]))
         bec_pkg::REG_TREND_COUNT:    prdata = 32'(trend_count_ff);
         bec_pkg::REG_LOCATION_COUNT: prdata = 32'(location_count_ff);
         bec_pkg::REG_SILL_FIRST:     prdata = sill_ff[0];
         bec_pkg::REG_SILL_SECOND:    prdata = sill_ff[1];
         bec_pkg::REG_SILL_THIRD:     prdata = sill_ff[2];
         bec_pkg::REG_RANGE_FIRST:    prdata = range_ff[0];
         bec_pkg::REG_RANGE_SECOND:   prdata = range_ff[1];
         bec_pkg::REG_RANGE_THIRD:    prdata = range_ff[2];
         default:                     prdata = '0;
      endcase
   end

   // Decode stage.
   bec_pkg::div_type front_ff;
   bec_pkg::div_type front_in;
   logic             front_v_ff;
   logic             front_rdy;
   logic             div_in_stall;

   always_comb begin
      logic [LW-1:0]            nl;
      logic [LW-1:0]            base;
      logic [LW-1:0]            loc_i;
      logic [LW-1:0]            loc_j;
      logic [31:0]              sill;
      logic [31:0]              range;
      logic [bec_pkg::NUM_W-1:0] num;
      nl    = (LW'(location_count_ff) > MaxLocs) ? MaxLocs : LW'(location_count_ff);
      loc_i = LW'(req_data.first_location);
      loc_j = LW'(req_data.second_location);
      case (req_data.trend_index)
         2'd0:    begin base = '0;            sill = sill_ff[0]; range = range_ff[0]; end
         2'd1:    begin base = nl;            sill = sill_ff[1]; range = range_ff[1]; end
         2'd2:    begin base = LW'(nl << 1);  sill = sill_ff[2]; range = range_ff[2]; end
         default: begin base = '0;            sill = '0;         range = '0;          end
      endcase
      num                 = {req_data.distance, bec_pkg::XF'(0)};
      front_in            = '0;
      front_in.side.err   = (req_data.trend_index >= trend_count_ff)
                            || (32'(req_data.trend_index) >= 32'(bec_pkg::MAX_TRENDS))
                            || (loc_i >= nl) || (loc_j >= nl) || (range == '0);
      front_in.side.diag  = (req_data.first_location == req_data.second_location);
      front_in.side.zero  = ({4'b0, req_data.distance} >= {range, 4'b0});
      front_in.side.pos_i = bec_pkg::POS_W'(base + loc_i);
      front_in.side.pos_j = bec_pkg::POS_W'(base + loc_j);
      front_in.side.sill  = sill;
      front_in.range      = range;
      // The dividend bits above the quotient lie below the range whenever the
      // ratio is under 16, so they start as the partial remainder.
      front_in.rem        = 32'(num[bec_pkg::NUM_W-1:bec_pkg::Q_W]);
      front_in.stream     = num[bec_pkg::Q_W-1:0];
   end

   assign front_rdy = !front_v_ff || !div_in_stall;
   assign req_stall = !front_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else if (front_rdy) begin
         front_v_ff <= req_valid;
      end
      if (front_rdy) begin
         front_ff <= front_in;
      end
   end

   bec_pkg::quo_type div_out;
   logic             div_out_valid;
   logic             div_out_stall;

   bec_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_data   (front_ff),
      .in_valid  (front_v_ff),
      .in_stall  (div_in_stall),
      .out_data  (div_out),
      .out_valid (div_out_valid),
      .out_stall (div_out_stall)
   );

   bec_pkg::cov_type exp_out;
   logic             exp_out_valid;
   logic             exp_out_stall;

   bec_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_data   (div_out),
      .in_valid  (div_out_valid),
      .in_stall  (div_out_stall),
      .out_data  (exp_out),
      .out_valid (exp_out_valid),
      .out_stall (exp_out_stall)
   );

   // Result register; an off-diagonal pair is sent as two transactions.
   bec_pkg::cov_type out_ff;
   logic             out_v_ff;
   logic             phase_ff;
   logic             out_final;
   logic             out_load;

   assign out_final     = out_ff.side.err || out_ff.side.diag || phase_ff;
   assign out_load      = !out_v_ff || (!rsp_stall && out_final);
   assign exp_out_stall = !out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (out_load) begin
         out_v_ff <= exp_out_valid;
         phase_ff <= 1'b0;
      end else if (!rsp_stall) begin
         phase_ff <= 1'b1;
      end
      if (out_load) begin
         out_ff <= exp_out;
      end
   end

   always_comb begin
      rsp_data = '0;
      if (out_ff.side.err) begin
         rsp_data.last_of_run = 1'b1;
         rsp_data.error_flag  = 1'b1;
      end else if (out_ff.side.diag) begin
         rsp_data.row_position    = out_ff.side.pos_i;
         rsp_data.column_position = out_ff.side.pos_i;
         rsp_data.covariance      = out_ff.side.sill;
         rsp_data.last_of_run     = 1'b1;
      end else begin
         rsp_data.row_position    = phase_ff ? out_ff.side.pos_i : out_ff.side.pos_j;
         rsp_data.column_position = phase_ff ? out_ff.side.pos_j : out_ff.side.pos_i;
         rsp_data.covariance      = out_ff.side.zero ? 32'd0 : out_ff.cov;
         rsp_data.last_of_run     = phase_ff;
      end
   end

   assign rsp_valid = out_v_ff;

endmodule
